[hdl/multiply_xor_block_hash32_unit_assert.svh]
// Assertion macros shared by the checker of the block hash unit.
`ifndef MULTIPLY_XOR_BLOCK_HASH32_UNIT_ASSERT_SVH
`define MULTIPLY_XOR_BLOCK_HASH32_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MXBH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MXBH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mxbh_pkg.sv]
// Shared types and constants of the block hash unit.
package mxbh_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QFILL_W = QPTR_W + 1;
  localparam int BLOCK_BYTES = 8;

  // One classified block as it waits between the front and back parts.
  typedef struct packed {
    logic [31:0] t_inv;    // complement of the low word
    logic [31:0] t_sum;    // low word plus the block's byte position
    logic [15:0] h;        // xor of the two upper halves
    logic        has_term; // at least one valid byte
    logic        last;     // final block of the message
    logic [31:0] length;   // message length so far, modulo 2^32
  } entry_t;

  // Occupancy flags of the block queue.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[hdl/mxbh_front.sv]
// Front part: accepts blocks, masks missing bytes and tracks the byte position.
module mxbh_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             block_valid,
  output logic             block_ready,
  input  logic [63:0]      block_data,
  input  logic [3:0]       byte_count,
  input  logic             last_block,
  input  mxbh_pkg::queue_status_t q_status,
  output logic             q_push,
  output mxbh_pkg::entry_t q_entry
);
  import mxbh_pkg::*;

  logic [31:0] byte_offset;
  logic [31:0] byte_offset_next;
  logic [3:0]  count_clamped;
  logic [63:0] data_masked;
  logic [31:0] length_now;

  // A count above eight means a full block.
  assign count_clamped = byte_count[3] ? 4'(BLOCK_BYTES) : byte_count;

  // Bytes beyond the valid count read as zero.
  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      data_masked[i*8 +: 8] = (4'(i) < count_clamped) ? block_data[i*8 +: 8] : 8'h00;
    end
  end

  assign length_now  = byte_offset + {28'd0, count_clamped};
  assign block_ready = !q_status.full;
  assign q_push      = block_valid && block_ready;

  // Build the queue entry for the back part.
  always_comb begin
    q_entry.t_inv    = ~data_masked[31:0];
    q_entry.t_sum    = data_masked[31:0] + byte_offset;
    q_entry.h        = data_masked[47:32] ^ data_masked[63:48];
    q_entry.has_term = (count_clamped != 4'd0);
    q_entry.last     = last_block;
    q_entry.length   = length_now;
  end

  // The position restarts after the last block of a message.
  always_comb begin
    byte_offset_next = byte_offset;
    if (q_push) begin
      byte_offset_next = last_block ? 32'd0 : length_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= 32'd0;
    end else begin
      byte_offset <= byte_offset_next;
    end
  end

endmodule

[hdl/mxbh_queue.sv]
// Short queue of classified blocks between the front and back parts.
module mxbh_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mxbh_pkg::entry_t push_entry,
  input  logic             pop,
  output mxbh_pkg::entry_t head_entry,
  output mxbh_pkg::queue_status_t status
);
  import mxbh_pkg::*;

  entry_t             mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (fill == QFILL_W'(QDEPTH));
  assign status.empty = (fill == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_entry   = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + QFILL_W'(1);
        2'b01:   fill <= fill - QFILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hdl/mxbh_back.sv]
// Back part: multiplies, accumulates the block terms and holds the result.
module mxbh_back (
  input  logic             clk,
  input  logic             rst,
  input  mxbh_pkg::queue_status_t q_status,
  input  mxbh_pkg::entry_t head_entry,
  output logic             q_pop,
  output logic             hash_valid,
  input  logic             hash_ready,
  output logic [31:0]      hash_value
);
  import mxbh_pkg::*;

  // Product stage.
  logic        prod_valid;
  logic [31:0] prod_p;
  logic [31:0] prod_q;
  logic        prod_has_term;
  logic        prod_last;
  logic [31:0] prod_length;

  logic [31:0] running_xor;
  logic [31:0] running_xor_next;
  logic [31:0] term;
  logic        advance;
  logic        load_prod;
  logic [31:0] h_ext;
  logic [31:0] h_inv_ext;

  assign h_ext     = {{16{head_entry.h[15]}}, head_entry.h};
  assign h_inv_ext = {{16{~head_entry.h[15]}}, ~head_entry.h};

  // The product stage moves on unless a result would overrun a waiting one.
  assign advance   = prod_valid && (!prod_last || !hash_valid || hash_ready);
  assign load_prod = !prod_valid || advance;
  assign q_pop     = load_prod && !q_status.empty;

  assign term = prod_has_term ? (prod_p ^ prod_q) : 32'd0;

  // The running value clears once a message is finished.
  always_comb begin
    running_xor_next = running_xor;
    if (advance) begin
      running_xor_next = prod_last ? 32'd0 : (running_xor ^ term);
    end
  end

  // Product registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_p        <= 32'(head_entry.t_inv * h_ext);
      prod_q        <= 32'(head_entry.t_sum * h_inv_ext);
      prod_has_term <= head_entry.has_term;
      prod_last     <= head_entry.last;
      prod_length   <= head_entry.length;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance && prod_last) begin
      hash_value <= running_xor ^ term ^ prod_length;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid  <= 1'b0;
      hash_valid  <= 1'b0;
      running_xor <= 32'd0;
    end else begin
      if (load_prod) begin
        prod_valid <= !q_status.empty;
      end
      if (advance && prod_last) begin
        hash_valid <= 1'b1;
      end else if (hash_ready) begin
        hash_valid <= 1'b0;
      end
      running_xor <= running_xor_next;
    end
  end

endmodule

[hdl/multiply_xor_block_hash32_unit.sv]
// A last block passes the queue, the product and the result registers to reach hash_valid.
// Throughput: one 8-byte block per cycle while block_ready, set by the single product stage.
// A four-entry queue lets the front keep taking blocks while a result waits to be taken.
// Reset (rst, synchronous, active high) empties the queue, drops any pending result
// and clears the running xor and byte position.
module multiply_xor_block_hash32_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        block_valid,
  output logic        block_ready,
  input  logic [63:0] block_data,
  input  logic [3:0]  byte_count,
  input  logic        last_block,
  output logic        hash_valid,
  input  logic        hash_ready,
  output logic [31:0] hash_value
);
  import mxbh_pkg::*;

  queue_status_t q_status;
  entry_t        push_entry;
  entry_t        head_entry;
  logic          q_push;
  logic          q_pop;

  mxbh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .block_valid (block_valid),
    .block_ready (block_ready),
    .block_data  (block_data),
    .byte_count  (byte_count),
    .last_block  (last_block),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_entry     (push_entry)
  );

  mxbh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head_entry (head_entry),
    .status     (q_status)
  );

  mxbh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .head_entry (head_entry),
    .q_pop      (q_pop),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash_value (hash_value)
  );

endmodule

[hdl/mxbh_checker.sv]
// Port-level checker of the block hash unit and its binding to the top level.
`include "multiply_xor_block_hash32_unit_assert.svh"

module mxbh_checker (
  input logic        clk,
  input logic        rst,
  input logic        block_valid,
  input logic        block_ready,
  input logic        last_block,
  input logic        hash_valid,
  input logic        hash_ready,
  input logic [31:0] hash_value
);
  // Requests in flight: queue, product stage and result register.
  localparam logic [3:0] MaxPending = 4'd6;

  logic [3:0] pending;
  logic       msg_in;
  logic       msg_out;

  assign msg_in  = block_valid && block_ready && last_block;
  assign msg_out = hash_valid && hash_ready;

  // Count finished messages whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 4'd0;
    end else begin
      case ({msg_in, msg_out})
        2'b10:   pending <= pending + 4'd1;
        2'b01:   pending <= pending - 4'd1;
        default: pending <= pending;
      endcase
    end
  end

  `MXBH_ASSERT_NEXT(a_hash_held, hash_valid && !hash_ready, hash_valid, "result dropped")
  `MXBH_ASSERT_NEXT(a_value_held, hash_valid && !hash_ready, $stable(hash_value), "value changed")
  `MXBH_ASSERT_NOW(a_no_invented, hash_valid, pending != 4'd0, "result without a finished message")
  `MXBH_ASSERT_NOW(a_bounded, 1'b1, pending <= MaxPending, "more messages in flight than storage")

endmodule

bind multiply_xor_block_hash32_unit mxbh_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .block_valid (block_valid),
  .block_ready (block_ready),
  .last_block  (last_block),
  .hash_valid  (hash_valid),
  .hash_ready  (hash_ready),
  .hash_value  (hash_value)
);
